/* design/lzbd_pkg.sv */
// shared types, constants and helpers for the lz back-reference decompressor
package lzbd_pkg;

    // history defaults and byte counter limit
    localparam int unsigned DEFAULT_HISTORY_DEPTH = 131072;
    localparam int unsigned DIST_W                = 18;
    localparam logic [DIST_W-1:0] PROD_MAX        = 18'h3ffff;

    // packet geometry of the result stream
    localparam int unsigned PACKET_BYTES = 32;
    localparam int unsigned PKT_LANES    = 32;
    localparam int unsigned LANE_W       = $clog2(PKT_LANES);
    localparam int unsigned CNT_W        = 6;
    localparam int unsigned LEN_W        = 11;
    localparam int unsigned LIT_W        = 7;
    localparam int unsigned TDATA_W      = 8 * ((PKT_LANES * 8 + CNT_W + 7) / 8);
    localparam int unsigned TDATA_PAD    = TDATA_W - PKT_LANES * 8 - CNT_W;
    localparam int unsigned TUSER_W      = 2;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PARSE,
        ST_DECODE,
        ST_CHECK,
        ST_ERR,
        ST_END,
        ST_RD,
        ST_WR
    } t_state;

    // what the next input byte is
    typedef enum logic [2:0] {
        PH_CMD,
        PH_HDR1,
        PH_HDR2,
        PH_HDR3,
        PH_LIT
    } t_phase;

    // what follows the last literal of a command
    typedef enum logic [1:0] {
        KIND_COPY,
        KIND_RUN,
        KIND_END
    } t_kind;

    // request from the sequencer to the packet builder
    typedef struct packed {
        logic       put;
        logic [7:0] data;
        logic       push;
        logic       eos;
        logic       err;
        logic       last;
    } t_pk_req;

    // packet builder status back to the sequencer
    typedef struct packed {
        logic free;
        logic full_next;
    } t_pk_stat;

    // classify a command byte
    function automatic t_kind f_cmd_kind(input logic [7:0] c);
        logic [7:0] size;
        size = {1'b0, c[4:0], 2'b00} + 8'd4;
        if (c[7:5] == 3'b111) begin
            return (size > 8'h70) ? KIND_END : KIND_RUN;
        end
        return KIND_COPY;
    endfunction

endpackage

/* design/lzbd_ram.sv */
// generic single-write, single-read ram with registered read data
module lzbd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/lzbd_pack.sv */
// packet builder: collects bytes into a 32-lane packet and holds the output register
module lzbd_pack (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lzbd_pkg::t_pk_req               i_req,
    output lzbd_pkg::t_pk_stat              o_stat,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [lzbd_pkg::TDATA_W-1:0]    o_tdata,
    output logic [lzbd_pkg::TUSER_W-1:0]    o_tuser,
    output logic                            o_tlast
);
    import lzbd_pkg::*;

    logic [PKT_LANES-1:0][7:0] r_buf;
    logic [PKT_LANES-1:0][7:0] n_buf;
    logic [PKT_LANES-1:0][7:0] w_buf_put;
    logic [CNT_W-1:0]          r_fill;
    logic [CNT_W-1:0]          n_fill;
    logic [CNT_W-1:0]          w_cnt;
    logic                      r_tvalid;
    logic [TDATA_W-1:0]        r_tdata;
    logic [TUSER_W-1:0]        r_tuser;
    logic                      r_tlast;

    // place the incoming byte at the fill position, clear the buffer once sent
    always_comb begin
        w_buf_put = r_buf;
        w_cnt     = r_fill;
        if (i_req.put) begin
            w_buf_put[r_fill[LANE_W-1:0]] = i_req.data;
            w_cnt                         = r_fill + CNT_W'(1);
        end
        n_buf  = i_req.push ? '0 : w_buf_put;
        n_fill = i_req.push ? '0 : w_cnt;
    end

    // status for the sequencer
    assign o_stat.free      = !r_tvalid || i_tready;
    assign o_stat.full_next = (r_fill + CNT_W'(1)) == CNT_W'(PACKET_BYTES);

    // packet buffer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf    <= '0;
            r_fill   <= '0;
            r_tvalid <= 1'b0;
        end else begin
            r_buf  <= n_buf;
            r_fill <= n_fill;
            if (i_req.push) begin
                r_tvalid <= 1'b1;
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            r_tdata <= {{TDATA_PAD{1'b0}}, w_cnt, w_buf_put};
            r_tuser <= {i_req.err, i_req.eos};
            r_tlast <= i_req.last;
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;
    assign o_tlast  = r_tlast;

endmodule

/* design/lzbd_ctrl.sv */
// command parser and byte-serial copy sequencer around the history address unit
module lzbd_ctrl #(
    parameter int unsigned HISTORY_DEPTH = lzbd_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_in_byte,
    output logic                             o_ram_we,
    output logic [$clog2(HISTORY_DEPTH)-1:0] o_ram_waddr,
    output logic [7:0]                       o_ram_wdata,
    output logic                             o_ram_re,
    output logic [$clog2(HISTORY_DEPTH)-1:0] o_ram_raddr,
    input  logic [7:0]                       i_ram_rdata,
    output lzbd_pkg::t_pk_req                o_pk_req,
    input  lzbd_pkg::t_pk_stat               i_pk_stat
);
    import lzbd_pkg::*;

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);
    localparam logic [DIST_W-1:0] DEPTH_D = DIST_W'(HISTORY_DEPTH);
    localparam logic [AW-1:0] WP_LAST = AW'(HISTORY_DEPTH - 1);

    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [7:0]          r_byte, n_byte;
    logic [7:0]          r_cmd, n_cmd;
    logic [7:0]          r_h1, n_h1;
    logic [7:0]          r_h2, n_h2;
    logic [7:0]          r_h3, n_h3;
    logic [LIT_W-1:0]    r_lit, n_lit;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [DIST_W-1:0]   r_dist, n_dist;
    logic [AW-1:0]       r_wp, n_wp;
    logic [DIST_W-1:0]   r_prod, n_prod;

    logic [7:0]          w_run_size;
    logic [LIT_W-1:0]    w_run_lit;
    logic [LIT_W-1:0]    w_dec_lit;
    logic [LEN_W-1:0]    w_dec_len;
    logic [DIST_W-1:0]   w_dec_dist;
    logic [DIST_W-1:0]   w_wp_ext;
    logic [DIST_W-1:0]   w_src;
    logic [AW-1:0]       w_wp_inc;
    logic [DIST_W-1:0]   w_prod_inc;
    logic                w_need_push;

    // literal count of a run or end command
    assign w_run_size = {1'b0, r_byte[4:0], 2'b00} + 8'd4;
    assign w_run_lit  = (w_run_size > 8'h70) ? LIT_W'(r_byte[1:0]) : w_run_size[LIT_W-1:0];

    // header decode for the three back-reference forms
    always_comb begin
        if (!r_cmd[7]) begin
            w_dec_lit  = LIT_W'(r_cmd[1:0]);
            w_dec_len  = LEN_W'(r_cmd[4:2]) + LEN_W'(3);
            w_dec_dist = DIST_W'({r_cmd[6:5], r_h1}) + DIST_W'(1);
        end else if (!r_cmd[6]) begin
            w_dec_lit  = LIT_W'(r_h1[7:6]);
            w_dec_len  = LEN_W'(r_cmd[5:0]) + LEN_W'(4);
            w_dec_dist = DIST_W'({r_h1[5:0], r_h2}) + DIST_W'(1);
        end else begin
            w_dec_lit  = LIT_W'(r_cmd[1:0]);
            w_dec_len  = LEN_W'({r_cmd[3:2], r_h3}) + LEN_W'(5);
            w_dec_dist = DIST_W'({r_cmd[4], r_h1, r_h2}) + DIST_W'(1);
        end
    end

    // shared address unit: copy source behind the write pointer, pointer step
    assign w_wp_ext   = DIST_W'(r_wp);
    assign w_src      = (w_wp_ext >= r_dist) ? (w_wp_ext - r_dist)
                                             : (w_wp_ext + (DEPTH_D - r_dist));
    assign w_wp_inc   = (r_wp == WP_LAST) ? '0 : r_wp + AW'(1);
    assign w_prod_inc = (r_prod == PROD_MAX) ? r_prod : r_prod + DIST_W'(1);
    assign w_need_push = i_pk_stat.full_next || (r_len == LEN_W'(1));

    // next state and outputs
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_byte      = r_byte;
        n_cmd       = r_cmd;
        n_h1        = r_h1;
        n_h2        = r_h2;
        n_h3        = r_h3;
        n_lit       = r_lit;
        n_len       = r_len;
        n_dist      = r_dist;
        n_wp        = r_wp;
        n_prod      = r_prod;
        o_in_ready  = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_wp;
        o_ram_wdata = r_byte;
        o_ram_re    = 1'b0;
        o_ram_raddr = w_src[AW-1:0];
        o_pk_req    = '0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_byte  = i_in_byte;
                    n_state = ST_PARSE;
                end
            end

            ST_PARSE: begin
                unique case (r_phase)
                    PH_CMD: begin
                        n_cmd = r_byte;
                        if (r_byte[7:5] == 3'b111) begin
                            if (w_run_lit == '0) begin
                                // end form with no trailing literals
                                n_wp    = '0;
                                n_prod  = '0;
                                n_state = ST_END;
                            end else begin
                                n_lit   = w_run_lit;
                                n_phase = PH_LIT;
                                n_state = ST_IDLE;
                            end
                        end else begin
                            n_phase = PH_HDR1;
                            n_state = ST_IDLE;
                        end
                    end
                    PH_HDR1: begin
                        n_h1 = r_byte;
                        if (!r_cmd[7]) begin
                            n_state = ST_DECODE;
                        end else begin
                            n_phase = PH_HDR2;
                            n_state = ST_IDLE;
                        end
                    end
                    PH_HDR2: begin
                        n_h2 = r_byte;
                        if (!r_cmd[6]) begin
                            n_state = ST_DECODE;
                        end else begin
                            n_phase = PH_HDR3;
                            n_state = ST_IDLE;
                        end
                    end
                    PH_HDR3: begin
                        n_h3    = r_byte;
                        n_state = ST_DECODE;
                    end
                    PH_LIT: begin
                        // literal goes to history and out as its own packet
                        if (i_pk_stat.free) begin
                            o_ram_we      = 1'b1;
                            n_wp          = w_wp_inc;
                            n_prod        = w_prod_inc;
                            o_pk_req.put  = 1'b1;
                            o_pk_req.data = r_byte;
                            o_pk_req.push = 1'b1;
                            o_pk_req.last = 1'b1;
                            n_lit         = r_lit - LIT_W'(1);
                            n_state       = ST_IDLE;
                            if (r_lit == LIT_W'(1)) begin
                                n_phase = PH_CMD;
                                unique case (f_cmd_kind(r_cmd))
                                    KIND_END: begin
                                        o_pk_req.eos = 1'b1;
                                        n_wp         = '0;
                                        n_prod       = '0;
                                    end
                                    KIND_RUN: begin
                                        n_state = ST_IDLE;
                                    end
                                    KIND_COPY: begin
                                        o_pk_req.last = 1'b0;
                                        n_state       = ST_CHECK;
                                    end
                                    default: begin
                                        n_state = ST_IDLE;
                                    end
                                endcase
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_CMD;
                        n_state = ST_IDLE;
                    end
                endcase
            end

            ST_DECODE: begin
                n_lit  = w_dec_lit;
                n_len  = w_dec_len;
                n_dist = w_dec_dist;
                if (w_dec_lit == '0) begin
                    n_phase = PH_CMD;
                    n_state = ST_CHECK;
                end else begin
                    n_phase = PH_LIT;
                    n_state = ST_IDLE;
                end
            end

            ST_CHECK: begin
                if ((r_dist == '0) || (r_dist > r_prod) || (r_dist > DEPTH_D)) begin
                    n_state = ST_ERR;
                end else begin
                    n_state = ST_RD;
                end
            end

            ST_ERR: begin
                if (i_pk_stat.free) begin
                    o_pk_req.push = 1'b1;
                    o_pk_req.err  = 1'b1;
                    o_pk_req.last = 1'b1;
                    n_state       = ST_IDLE;
                end
            end

            ST_END: begin
                if (i_pk_stat.free) begin
                    o_pk_req.push = 1'b1;
                    o_pk_req.eos  = 1'b1;
                    o_pk_req.last = 1'b1;
                    n_state       = ST_IDLE;
                end
            end

            ST_RD: begin
                o_ram_re = 1'b1;
                n_state  = ST_WR;
            end

            ST_WR: begin
                // copied byte is written back and appended to the packet
                if (!w_need_push || i_pk_stat.free) begin
                    o_ram_we      = 1'b1;
                    o_ram_wdata   = i_ram_rdata;
                    n_wp          = w_wp_inc;
                    n_prod        = w_prod_inc;
                    o_pk_req.put  = 1'b1;
                    o_pk_req.data = i_ram_rdata;
                    o_pk_req.push = w_need_push;
                    o_pk_req.last = (r_len == LEN_W'(1));
                    n_len         = r_len - LEN_W'(1);
                    n_state       = (r_len == LEN_W'(1)) ? ST_IDLE : ST_RD;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_CMD;
            r_cmd   <= '0;
            r_h1    <= '0;
            r_h2    <= '0;
            r_h3    <= '0;
            r_lit   <= '0;
            r_len   <= '0;
            r_dist  <= '0;
            r_wp    <= '0;
            r_prod  <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_h1    <= n_h1;
            r_h2    <= n_h2;
            r_h3    <= n_h3;
            r_lit   <= n_lit;
            r_len   <= n_len;
            r_dist  <= n_dist;
            r_wp    <= n_wp;
            r_prod  <= n_prod;
        end
    end

    // input byte holding register
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule

/* design/lz_backref_decompressor.sv */
// Byte-serial LZ back-reference decompressor. One compressed byte is taken at a
// time; each command or header byte is registered and then parsed, and a
// literal leaves as a one-byte packet. A back-reference adds a decode and a
// distance check, then a read state and a write state per copied byte: every byte
// is read from the history RAM and written back at the write pointer through
// its single read and write port, and a copy goes out in packets of up to 32
// bytes, the last one flagged with tlast. The input is not ready while a byte
// is being worked on, and the sequencer also waits whenever a packet must
// leave while the output register is still full. The history is not cleared
// after reset; copies only reach bytes written in the current stream.
module lz_backref_decompressor #(
    parameter int unsigned HISTORY_DEPTH = lzbd_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // in_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // bytes_0_7, bytes_8_15, bytes_16_23, bytes_24_31, byte_count, zero pad
    output logic [lzbd_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic [lzbd_pkg::TUSER_W-1:0]  m_axis_tuser,  // end_of_stream, distance_error
    output logic                          m_axis_tlast   // last_of_run
);
    import lzbd_pkg::*;

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);

    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic [7:0]    w_ram_wdata;
    logic          w_ram_re;
    logic [AW-1:0] w_ram_raddr;
    logic [7:0]    w_ram_rdata;
    t_pk_req       w_pk_req;
    t_pk_stat      w_pk_stat;

    // parser and copy sequencer
    lzbd_ctrl #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_byte   (s_axis_tdata),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata),
        .o_pk_req    (w_pk_req),
        .i_pk_stat   (w_pk_stat)
    );

    // history of produced bytes
    lzbd_ram #(
        .WIDTH(8),
        .DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // packet builder and output register
    lzbd_pack u_pack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_pk_req),
        .o_stat   (w_pk_stat),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

`ifndef SYNTH
    // a packet is only handed over when the output register can take it
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pk_req.push |-> w_pk_stat.free)
        else $error("packet pushed while output register busy");

    // no packet carries more than the packet size
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[PKT_LANES*8 +: CNT_W] <= CNT_W'(PACKET_BYTES)))
        else $error("packet byte count above packet size");

    // a dropped copy reports no bytes and closes the run
    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |->
            ((m_axis_tdata[PKT_LANES*8 +: CNT_W] == '0) && m_axis_tlast))
        else $error("distance error result carries data");

    // one byte in flight: ready drops right after an accepted request
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request taken while busy");
`endif

endmodule

/* tb/tb_lz_backref_decompressor.sv */
// testbench for the lz back-reference decompressor: directed table plus random command streams
`timescale 1ns / 100ps

module tb_lz_backref_decompressor;
    import lzbd_pkg::*;

    localparam int unsigned HIST_DEPTH = DEFAULT_HISTORY_DEPTH;
    localparam int unsigned PTR_W      = $clog2(HIST_DEPTH);
    localparam int unsigned PKT_W      = PKT_LANES * 8;
    localparam int          MAX_RUN    = 'h70;
    localparam int          RAND_ITEMS = 200;
    localparam int          N_PHASES   = 4;
    // a 1028-byte copy keeps the input busy but its packets keep leaving meanwhile,
    // so the watchdog limit of quiet cycles is only reached when something is stuck
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          TAIL_CYCLES    = 64;

    // one output packet as the predictor sees it
    typedef struct {
        logic [PKT_W-1:0] bytes;
        logic [5:0]       count;
        logic             last;
        logic             eos;
        logic             err;
    } t_packet;

    // how a directed row is checked
    typedef enum logic {
        CHK_MODEL,
        CHK_TYPED
    } t_check;

    typedef struct {
        logic [7:0] in_byte;
        t_check     chk;
        logic [7:0] b0;
        logic [5:0] cnt;
        logic       eos;
        logic       err;
    } t_row;

    // dut ports
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = 8'h00;   // in_byte
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // bytes_0_7, bytes_8_15, bytes_16_23, bytes_24_31, byte_count, zero pad
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [TUSER_W-1:0] m_axis_tuser;           // end_of_stream, distance_error
    logic               m_axis_tlast;           // last_of_run

    // predictor state
    logic [7:0]        hist_mem [HIST_DEPTH];
    t_phase            parse_state;
    logic [7:0]        cmd_reg, hdr1, hdr2, hdr3;
    logic [LIT_W-1:0]  lits_left;
    logic [LEN_W-1:0]  copy_len;
    logic [DIST_W-1:0] copy_dist;
    logic [PTR_W-1:0]  wr_ptr;
    logic [DIST_W-1:0] produced;

    t_packet step_packets[$];
    t_packet expected_packets[$];
    t_row    stim_rows[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_plan[N_PHASES]  = '{0, 77, 0, 9};
    int stall_plan[N_PHASES] = '{0, 0, 77, 9};
    int sent_count    = 0;
    int checked_count = 0;
    int mismatches    = 0;
    int stall_cycles  = 0;

    lz_backref_decompressor i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // ---------------- predictor ----------------

    task automatic emit_packet(input logic [PKT_W-1:0] b, input int cnt,
                               input logic eos, input logic err);
        t_packet p;
        p.bytes = b;
        p.count = 6'(cnt);
        p.last  = 1'b0;
        p.eos   = eos;
        p.err   = err;
        step_packets.push_back(p);
    endtask

    task automatic put_hist(input logic [7:0] v);
        hist_mem[wr_ptr] = v;
        wr_ptr = wr_ptr + 1'b1;
        if (produced != PROD_MAX) produced = produced + 1'b1;
    endtask

    // runs whatever follows the last literal of a command
    task automatic close_command;
        t_packet          p;
        logic [PKT_W-1:0] acc;
        logic [7:0]       v;
        int               fill;
        int               src;
        parse_state = PH_CMD;
        if (cmd_reg[7:5] == 3'b111) begin
            // end form: flag the stream end and start a fresh stream
            if (int'(cmd_reg[4:0]) * 4 + 4 > MAX_RUN) begin
                if (step_packets.size() > 0) begin
                    p = step_packets.pop_back();
                    p.eos = 1'b1;
                    step_packets.push_back(p);
                end else begin
                    emit_packet('0, 0, 1'b1, 1'b0);
                end
                wr_ptr   = '0;
                produced = '0;
            end
        end else if (copy_dist == 0 || copy_dist > produced || copy_dist > HIST_DEPTH) begin
            emit_packet('0, 0, 1'b0, 1'b1);
        end else begin
            // byte-serial copy, so overlapping sources repeat
            acc  = '0;
            fill = 0;
            for (int k = 0; k < int'(copy_len); k++) begin
                src = (int'(wr_ptr) + HIST_DEPTH - int'(copy_dist)) % HIST_DEPTH;
                v = hist_mem[src];
                put_hist(v);
                acc[fill*8 +: 8] = v;
                fill++;
                if (fill == PACKET_BYTES) begin
                    emit_packet(acc, fill, 1'b0, 1'b0);
                    acc  = '0;
                    fill = 0;
                end
            end
            if (fill > 0) emit_packet(acc, fill, 1'b0, 1'b0);
        end
    endtask

    task automatic decode_headers;
        if (!cmd_reg[7]) begin
            lits_left = LIT_W'(cmd_reg[1:0]);
            copy_len  = LEN_W'(cmd_reg[4:2]) + LEN_W'(3);
            copy_dist = DIST_W'({cmd_reg[6:5], hdr1}) + DIST_W'(1);
        end else if (!cmd_reg[6]) begin
            lits_left = LIT_W'(hdr1[7:6]);
            copy_len  = LEN_W'(cmd_reg[5:0]) + LEN_W'(4);
            copy_dist = DIST_W'({hdr1[5:0], hdr2}) + DIST_W'(1);
        end else begin
            lits_left = LIT_W'(cmd_reg[1:0]);
            copy_len  = LEN_W'(hdr3) + LEN_W'(5) + LEN_W'({cmd_reg[3:2], 8'h00});
            copy_dist = DIST_W'({cmd_reg[4], hdr1, hdr2}) + DIST_W'(1);
        end
    endtask

    // one compressed byte in, the packets it causes into step_packets
    task automatic decompress_byte(input logic [7:0] b);
        t_packet p;
        int      need;
        int      idx;
        int      size;
        step_packets.delete();
        case (parse_state)
            PH_CMD: begin
                cmd_reg = b;
                if (b[7:5] == 3'b111) begin
                    size = int'(b[4:0]) * 4 + 4;
                    lits_left = (size > MAX_RUN) ? LIT_W'(b[1:0]) : LIT_W'(size);
                    copy_len  = '0;
                    copy_dist = '0;
                    if (lits_left == 0) close_command();
                    else parse_state = PH_LIT;
                end else begin
                    parse_state = PH_HDR1;
                end
            end
            PH_HDR1, PH_HDR2, PH_HDR3: begin
                case (parse_state)
                    PH_HDR1: begin
                        hdr1 = b;
                        idx  = 1;
                    end
                    PH_HDR2: begin
                        hdr2 = b;
                        idx  = 2;
                    end
                    default: begin
                        hdr3 = b;
                        idx  = 3;
                    end
                endcase
                need = !cmd_reg[7] ? 1 : !cmd_reg[6] ? 2 : 3;
                if (idx >= need) begin
                    decode_headers();
                    if (lits_left == 0) close_command();
                    else parse_state = PH_LIT;
                end else begin
                    parse_state = (idx == 1) ? PH_HDR2 : PH_HDR3;
                end
            end
            default: begin
                put_hist(b);
                emit_packet(PKT_W'(b), 1, 1'b0, 1'b0);
                if (lits_left > 0) lits_left = lits_left - 1'b1;
                if (lits_left == 0) close_command();
            end
        endcase
        if (step_packets.size() > 0) begin
            p = step_packets.pop_back();
            p.last = 1'b1;
            step_packets.push_back(p);
        end
    endtask

    // ---------------- stimulus ----------------

    // one input request; the predictor runs on acceptance
    task automatic send_byte(input logic [7:0] b, input bit use_model);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_count++;
        decompress_byte(b);
        if (use_model) foreach (step_packets[i]) expected_packets.push_back(step_packets[i]);
    endtask

    // sender holds off until every predicted packet has left
    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_packets.size() != 0);
    endtask

    task automatic add_row(input logic [7:0] b, input t_check chk, input logic [7:0] b0,
                           input logic [5:0] cnt, input logic eos, input logic err);
        t_row r;
        r.in_byte = b;
        r.chk     = chk;
        r.b0      = b0;
        r.cnt     = cnt;
        r.eos     = eos;
        r.err     = err;
        stim_rows.push_back(r);
    endtask

    // mostly reachable distances, short ones preferred so overlaps occur
    function automatic int pick_back_dist(input int reach, input int maxd, input bit ok);
        int lim;
        if (!ok) return $urandom_range(maxd, 1);
        lim = (reach < maxd) ? reach : maxd;
        if ($urandom_range(3) == 0) return $urandom_range(lim, 1);
        return $urandom_range((lim < 64) ? lim : 64, 1);
    endfunction

    // one well-formed command with random content, or a stray byte
    task automatic gen_command;
        int         pick, lits, reach, d, lenf;
        bit         ok;
        logic [7:0] c, h1, h2, h3;
        // a stray byte may leave the parser mid-command: push random bytes until aligned
        if (parse_state != PH_CMD) begin
            send_byte(8'($urandom), 1'b1);
            return;
        end
        pick  = $urandom_range(99);
        lits  = $urandom_range(3);
        reach = int'(produced) + lits;
        ok    = (reach > 0) && ($urandom_range(9) < 8);
        if (pick < 30) begin
            // short back-reference
            d = pick_back_dist(reach, 1024, ok);
            c = {1'b0, 2'((d - 1) >> 8), 3'($urandom_range(7)), 2'(lits)};
            send_byte(c, 1'b1);
            send_byte(8'(d - 1), 1'b1);
            repeat (lits) send_byte(8'($urandom), 1'b1);
        end else if (pick < 55) begin
            // medium back-reference
            d    = pick_back_dist(reach, 16384, ok);
            lenf = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(7);
            c  = {2'b10, 6'(lenf)};
            h1 = {2'(lits), 6'((d - 1) >> 8)};
            h2 = 8'(d - 1);
            send_byte(c, 1'b1);
            send_byte(h1, 1'b1);
            send_byte(h2, 1'b1);
            repeat (lits) send_byte(8'($urandom), 1'b1);
        end else if (pick < 70) begin
            // long back-reference, the longest lengths only now and then
            d    = pick_back_dist(reach, HIST_DEPTH, ok);
            lenf = ($urandom_range(9) == 0) ? $urandom_range(3) : 0;
            c  = {3'b110, 1'((d - 1) >> 16), 2'(lenf), 2'(lits)};
            h1 = 8'((d - 1) >> 8);
            h2 = 8'(d - 1);
            h3 = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15));
            send_byte(c, 1'b1);
            send_byte(h1, 1'b1);
            send_byte(h2, 1'b1);
            send_byte(h3, 1'b1);
            repeat (lits) send_byte(8'($urandom), 1'b1);
        end else if (pick < 85) begin
            // literal run, mostly short
            lenf = ($urandom_range(7) == 0) ? $urandom_range(27) : $urandom_range(3);
            send_byte({3'b111, 5'(lenf)}, 1'b1);
            repeat (lenf * 4 + 4) send_byte(8'($urandom), 1'b1);
        end else if (pick < 95) begin
            // end of stream with up to three trailing literals
            send_byte({6'b111111, 2'(lits)}, 1'b1);
            repeat (lits) send_byte(8'($urandom), 1'b1);
        end else begin
            send_byte(8'($urandom), 1'b1);
        end
    endtask

    // ---------------- checking ----------------

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // compare each output request with the oldest predicted packet
    always @(posedge i_clk) begin : result_monitor
        t_packet want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_packets.size() == 0) begin
                $error("output request with no packet expected");
                mismatches++;
            end else begin
                want = expected_packets.pop_front();
                check_field("bytes_0_7",   want.bytes[63:0],    m_axis_tdata[63:0]);
                check_field("bytes_8_15",  want.bytes[127:64],  m_axis_tdata[127:64]);
                check_field("bytes_16_23", want.bytes[191:128], m_axis_tdata[191:128]);
                check_field("bytes_24_31", want.bytes[255:192], m_axis_tdata[255:192]);
                check_field("byte_count", 64'(want.count), 64'(m_axis_tdata[PKT_W +: CNT_W]));
                check_field("last_of_run", 64'(want.last), 64'(m_axis_tlast));
                check_field("end_of_stream", 64'(want.eos), 64'(m_axis_tuser[0]));
                check_field("distance_error", 64'(want.err), 64'(m_axis_tuser[1]));
                checked_count++;
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        t_packet p;
        int      rand_start;
        parse_state = PH_CMD;
        cmd_reg     = '0;
        hdr1        = '0;
        hdr2        = '0;
        hdr3        = '0;
        lits_left   = '0;
        copy_len    = '0;
        copy_dist   = '0;
        wr_ptr      = '0;
        produced    = '0;

        // literal run of four with the byte extremes
        add_row(8'he0, CHK_MODEL, 8'h00, 6'd0, 1'b0, 1'b0);
        add_row(8'h00, CHK_TYPED, 8'h00, 6'd1, 1'b0, 1'b0);
        add_row(8'hff, CHK_TYPED, 8'hff, 6'd1, 1'b0, 1'b0);
        add_row(8'ha5, CHK_TYPED, 8'ha5, 6'd1, 1'b0, 1'b0);
        add_row(8'h5a, CHK_TYPED, 8'h5a, 6'd1, 1'b0, 1'b0);
        // short copy reaching past the four bytes produced
        add_row(8'h00, CHK_MODEL, 8'h00, 6'd0, 1'b0, 1'b0);
        add_row(8'hff, CHK_TYPED, 8'h00, 6'd0, 1'b0, 1'b1);
        // short copy with a literal, distance too far
        add_row(8'h61, CHK_MODEL, 8'h00, 6'd0, 1'b0, 1'b0);
        add_row(8'h00, CHK_MODEL, 8'h00, 6'd0, 1'b0, 1'b0);
        add_row(8'h11, CHK_MODEL, 8'h00, 6'd0, 1'b0, 1'b0);
        // medium copy, longest length, overlapping at distance three
        add_row(8'hbf, CHK_MODEL, 8'h00, 6'd0, 1'b0, 1'b0);
        add_row(8'h40, CHK_MODEL, 8'h00, 6'd0, 1'b0, 1'b0);
        add_row(8'h02, CHK_MODEL, 8'h00, 6'd0, 1'b0, 1'b0);
        add_row(8'h44, CHK_MODEL, 8'h00, 6'd0, 1'b0, 1'b0);
        // long copy of 1028 bytes at distance one after a literal
        add_row(8'hcd, CHK_MODEL, 8'h00, 6'd0, 1'b0, 1'b0);
        add_row(8'h00, CHK_MODEL, 8'h00, 6'd0, 1'b0, 1'b0);
        add_row(8'h00, CHK_MODEL, 8'h00, 6'd0, 1'b0, 1'b0);
        add_row(8'hff, CHK_MODEL, 8'h00, 6'd0, 1'b0, 1'b0);
        add_row(8'h77, CHK_MODEL, 8'h00, 6'd0, 1'b0, 1'b0);
        // long copy at the largest distance
        add_row(8'hdc, CHK_MODEL, 8'h00, 6'd0, 1'b0, 1'b0);
        add_row(8'hff, CHK_MODEL, 8'h00, 6'd0, 1'b0, 1'b0);
        add_row(8'hff, CHK_MODEL, 8'h00, 6'd0, 1'b0, 1'b0);
        add_row(8'hff, CHK_TYPED, 8'h00, 6'd0, 1'b0, 1'b1);
        // end with one trailing literal, then end with none
        add_row(8'hfd, CHK_MODEL, 8'h00, 6'd0, 1'b0, 1'b0);
        add_row(8'h88, CHK_TYPED, 8'h88, 6'd1, 1'b1, 1'b0);
        add_row(8'hfc, CHK_TYPED, 8'h00, 6'd0, 1'b1, 1'b0);
        // fresh stream: distance one already too far
        add_row(8'h00, CHK_MODEL, 8'h00, 6'd0, 1'b0, 1'b0);
        add_row(8'h00, CHK_TYPED, 8'h00, 6'd0, 1'b0, 1'b1);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (stim_rows[i]) begin
            send_byte(stim_rows[i].in_byte, stim_rows[i].chk == CHK_MODEL);
            if (stim_rows[i].chk == CHK_TYPED) begin
                p.bytes       = '0;
                p.bytes[7:0]  = stim_rows[i].b0;
                p.count       = stim_rows[i].cnt;
                p.last        = 1'b1;
                p.eos         = stim_rows[i].eos;
                p.err         = stim_rows[i].err;
                expected_packets.push_back(p);
            end
        end
        wait_drained();

        // random command streams under each idling pattern
        rand_start = sent_count;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            send_idle_pct  = idle_plan[ph];
            recv_stall_pct = stall_plan[ph];
            while (sent_count - rand_start < (ph + 1) * RAND_ITEMS / N_PHASES) gen_command();
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("ran %0d input bytes (directed table and random commands, four idling phases)",
                 sent_count);
        $display("compared %0d output packets with the predictor", checked_count);
        if (mismatches == 0 && expected_packets.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
design/lzbd_pkg.sv
design/lzbd_ram.sv
design/lzbd_pack.sv
design/lzbd_ctrl.sv
design/lz_backref_decompressor.sv
tb/tb_lz_backref_decompressor.sv
